>>> hw/rtl/assert_macros.svh
// Assertion macros of the merge block RTL, used by its datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge out of reset
`define KSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition on one edge implies a consequence on the next
`define KSM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> hw/rtl/ksm_pkg.sv
// Shared types and constants of the k-way sorted stream merge
`default_nettype none

package ksm_pkg;

  localparam int SRC_W  = 3;
  localparam int TERM_W = 32;
  localparam int DOC_W  = 32;
  localparam int CFG_W  = 4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_KEY,
    ST_SEARCH,
    ST_CMP,
    ST_INSERT,
    ST_HEAD_RD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_item;
    logic head_write;
    logic fill_commit;
    logic build_init;
    logic scan_next;
    logic rd_scan;
    logic key_load;
    logic remove_head;
    logic dec_live;
    logic search_refill;
    logic rd_mid;
    logic search_step;
    logic insert;
    logic inc_count;
    logic rd_head;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic merging;
    logic fill_ok;
    logic fill_complete;
    logic merge_ok;
    logic item_ex;
    logic scan_done;
    logic scan_take;
    logic search_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/ksm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data
`default_nettype none

module ksm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> hw/rtl/ksm_ctrl.sv
// Sequencer of the merge: fill, order build, refill search and emission
`default_nettype none

module ksm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ksm_pkg::sts_t sts,
  output ksm_pkg::cmd_t cmd
);

  ksm_pkg::state_t state_r;
  ksm_pkg::state_t state_nxt;
  logic            building_r;
  logic            building_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ksm_pkg::ST_IDLE;
      building_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      building_r <= building_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    building_nxt = building_r;
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state_r)
      ksm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ksm_pkg::ST_DECODE;
        end
      end
      ksm_pkg::ST_DECODE: begin
        state_nxt = ksm_pkg::ST_IDLE;
        if (!sts.merging) begin
          if (sts.fill_ok) begin
            cmd.head_write  = 1'b1;
            cmd.fill_commit = 1'b1;
            if (sts.fill_complete) begin
              cmd.build_init = 1'b1;
              building_nxt   = 1'b1;
              state_nxt      = ksm_pkg::ST_SCAN;
            end
          end
        end else if (sts.merge_ok) begin
          cmd.remove_head = 1'b1;
          if (sts.item_ex) begin
            cmd.dec_live = 1'b1;
            state_nxt    = ksm_pkg::ST_HEAD_RD;
          end else begin
            cmd.head_write    = 1'b1;
            cmd.search_refill = 1'b1;
            state_nxt         = ksm_pkg::ST_SEARCH;
          end
        end
      end
      ksm_pkg::ST_SCAN: begin
        if (sts.scan_done) begin
          building_nxt = 1'b0;
          state_nxt    = ksm_pkg::ST_HEAD_RD;
        end else if (sts.scan_take) begin
          cmd.rd_scan = 1'b1;
          state_nxt   = ksm_pkg::ST_KEY;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      ksm_pkg::ST_KEY: begin
        cmd.key_load = 1'b1;
        state_nxt    = ksm_pkg::ST_SEARCH;
      end
      ksm_pkg::ST_SEARCH: begin
        if (sts.search_done) begin
          state_nxt = ksm_pkg::ST_INSERT;
        end else begin
          cmd.rd_mid = 1'b1;
          state_nxt  = ksm_pkg::ST_CMP;
        end
      end
      ksm_pkg::ST_CMP: begin
        cmd.search_step = 1'b1;
        state_nxt       = ksm_pkg::ST_SEARCH;
      end
      ksm_pkg::ST_INSERT: begin
        cmd.insert = 1'b1;
        if (building_r) begin
          cmd.inc_count = 1'b1;
          cmd.scan_next = 1'b1;
          state_nxt     = ksm_pkg::ST_SCAN;
        end else begin
          state_nxt = ksm_pkg::ST_HEAD_RD;
        end
      end
      ksm_pkg::ST_HEAD_RD: begin
        cmd.rd_head = 1'b1;
        state_nxt   = ksm_pkg::ST_EMIT;
      end
      ksm_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ksm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt    = ksm_pkg::ST_IDLE;
        building_nxt = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/ksm_dp.sv
// Datapath of the merge: head store, ordered source list, search and output register
`default_nettype none

`include "assert_macros.svh"

module ksm_dp #(
  parameter int MAX_SOURCES = 8,
  parameter int KEY_BITS    = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  input  logic [ksm_pkg::CFG_W-1:0]    cfg_data,
  input  logic [ksm_pkg::SRC_W-1:0]    in_source,
  input  logic [ksm_pkg::TERM_W-1:0]   in_term,
  input  logic [ksm_pkg::DOC_W-1:0]    in_doc,
  input  logic                         in_exhausted,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [ksm_pkg::TERM_W-1:0]   out_term,
  output logic [ksm_pkg::DOC_W-1:0]    out_doc,
  output logic [ksm_pkg::SRC_W-1:0]    out_source,
  output logic                         out_tuple_valid,
  output logic                         out_finished,
  input  ksm_pkg::cmd_t                cmd,
  output ksm_pkg::sts_t                sts
);

  localparam int NSRC  = MAX_SOURCES;
  localparam int SW    = $clog2(NSRC);
  localparam int CW    = $clog2(NSRC + 1);
  localparam int KW    = (KEY_BITS < ksm_pkg::DOC_W) ? KEY_BITS : ksm_pkg::DOC_W;
  localparam int RAM_W = ksm_pkg::TERM_W + ksm_pkg::DOC_W;
  localparam logic [ksm_pkg::CFG_W-1:0] ACT_RST = ksm_pkg::CFG_W'((NSRC < 8) ? NSRC : 8);
  localparam logic [NSRC-1:0] ONE_HOT0 = NSRC'(1);

  logic [ksm_pkg::CFG_W-1:0]  active_r;
  logic [ksm_pkg::CFG_W-1:0]  active_nxt;
  logic [NSRC-1:0]            filled_r;
  logic [NSRC-1:0]            live_r;
  logic                       merging_r;
  logic [CW-1:0]              count_r;
  logic [SW-1:0]              order_r [NSRC];
  logic [CW-1:0]              scan_r;
  logic [CW-1:0]              lo_r;
  logic [CW-1:0]              hi_r;
  logic                       out_valid_r;

  logic [ksm_pkg::SRC_W-1:0]  src_r;
  logic [ksm_pkg::TERM_W-1:0] term_r;
  logic [ksm_pkg::DOC_W-1:0]  doc_r;
  logic                       ex_r;
  logic [KW-1:0]              key_r;
  logic [SW-1:0]              val_r;
  logic                       strict_r;
  logic [ksm_pkg::TERM_W-1:0] out_term_r;
  logic [ksm_pkg::DOC_W-1:0]  out_doc_r;
  logic [ksm_pkg::SRC_W-1:0]  out_source_r;
  logic                       out_tuple_r;
  logic                       out_fin_r;

  logic [SW-1:0]              src_idx;
  logic [NSRC-1:0]            fill_set;
  logic [NSRC-1:0]            need;
  logic [CW:0]                mid_sum;
  logic [CW-1:0]              mid;
  logic                       ram_we;
  logic                       ram_re;
  logic [SW-1:0]              ram_raddr;
  logic [RAM_W-1:0]           ram_rdata;
  logic [KW-1:0]              rkey;
  logic                       go_right;

  assign src_idx  = SW'(src_r);
  assign fill_set = filled_r | (ONE_HOT0 << src_idx);
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid      = mid_sum[CW:1];
  assign rkey     = ram_rdata[ksm_pkg::TERM_W +: KW];
  assign go_right = strict_r ? (rkey < key_r) : (rkey <= key_r);
  assign ram_we   = cmd.head_write & ~ex_r;
  assign ram_re   = cmd.rd_scan | cmd.rd_mid | cmd.rd_head;

  always_comb begin
    for (int i = 0; i < NSRC; i++) begin
      need[i] = (i < int'(active_r));
    end
  end

  always_comb begin
    if (cmd.rd_scan) begin
      ram_raddr = scan_r[SW-1:0];
    end else if (cmd.rd_mid) begin
      ram_raddr = order_r[mid[SW-1:0]];
    end else begin
      ram_raddr = order_r[0];
    end
  end

  // clamp the written count to the supported range
  always_comb begin
    active_nxt = cfg_data;
    if (cfg_data == '0) begin
      active_nxt = ksm_pkg::CFG_W'(1);
    end else if (int'(cfg_data) > NSRC) begin
      active_nxt = ksm_pkg::CFG_W'(NSRC);
    end
  end

  always_comb begin
    sts               = '0;
    sts.merging       = merging_r;
    sts.fill_ok       = (int'(src_r) < NSRC) && ({1'b0, src_r} < active_r)
                        && !filled_r[src_idx];
    sts.fill_complete = ((fill_set & need) == need);
    sts.merge_ok      = (count_r != '0) && (int'(src_r) == int'(order_r[0]));
    sts.item_ex       = ex_r;
    sts.scan_done     = (int'(scan_r) == NSRC);
    sts.scan_take     = (int'(scan_r) < int'(active_r)) && live_r[scan_r[SW-1:0]];
    sts.search_done   = (lo_r == hi_r);
    sts.out_free      = !out_valid_r || out_ready;
  end

  ksm_ram #(
    .WIDTH (RAM_W),
    .DEPTH (NSRC)
  ) u_heads (
    .clk   (clk),
    .we    (ram_we),
    .waddr (src_idx),
    .wdata ({doc_r, term_r}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= ACT_RST;
      filled_r    <= '0;
      live_r      <= '0;
      merging_r   <= 1'b0;
      count_r     <= '0;
      scan_r      <= '0;
      lo_r        <= '0;
      hi_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NSRC; i++) begin
        order_r[i] <= SW'(i);
      end
    end else begin
      if (cfg_valid) begin
        active_r <= active_nxt;
      end
      if (cmd.fill_commit) begin
        filled_r <= fill_set;
        if (!ex_r) begin
          live_r[src_idx] <= 1'b1;
        end
      end
      if (cmd.build_init) begin
        merging_r <= 1'b1;
        count_r   <= '0;
        scan_r    <= '0;
      end else begin
        if (cmd.scan_next) begin
          scan_r <= scan_r + CW'(1);
        end
        if (cmd.inc_count) begin
          count_r <= count_r + CW'(1);
        end else if (cmd.dec_live) begin
          count_r <= count_r - CW'(1);
        end
      end
      if (cmd.key_load) begin
        lo_r <= '0;
        hi_r <= count_r;
      end else if (cmd.search_refill) begin
        lo_r <= '0;
        hi_r <= count_r - CW'(1);
      end else if (cmd.search_step) begin
        if (go_right) begin
          lo_r <= mid + CW'(1);
        end else begin
          hi_r <= mid;
        end
      end
      // drop the head, or open a gap and place the new entry
      if (cmd.remove_head) begin
        for (int i = 0; i < NSRC - 1; i++) begin
          order_r[i] <= order_r[i+1];
        end
        order_r[NSRC-1] <= order_r[0];
      end else if (cmd.insert) begin
        if (lo_r == '0) begin
          order_r[0] <= val_r;
        end
        for (int i = 1; i < NSRC; i++) begin
          if (i == int'(lo_r)) begin
            order_r[i] <= val_r;
          end else if (i > int'(lo_r)) begin
            order_r[i] <= order_r[i-1];
          end
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      src_r  <= in_source;
      term_r <= in_term;
      doc_r  <= in_doc;
      ex_r   <= in_exhausted;
    end
    if (cmd.key_load) begin
      key_r    <= rkey;
      val_r    <= SW'(scan_r);
      strict_r <= 1'b0;
    end else if (cmd.search_refill) begin
      key_r    <= doc_r[KW-1:0];
      val_r    <= src_idx;
      strict_r <= 1'b1;
    end
    if (cmd.emit) begin
      if (count_r == '0) begin
        out_term_r   <= '0;
        out_doc_r    <= '0;
        out_source_r <= '0;
        out_tuple_r  <= 1'b0;
        out_fin_r    <= 1'b1;
      end else begin
        out_term_r   <= ram_rdata[ksm_pkg::TERM_W-1:0];
        out_doc_r    <= ram_rdata[ksm_pkg::TERM_W +: ksm_pkg::DOC_W];
        out_source_r <= ksm_pkg::SRC_W'(order_r[0]);
        out_tuple_r  <= 1'b1;
        out_fin_r    <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_term        = out_term_r;
  assign out_doc         = out_doc_r;
  assign out_source      = out_source_r;
  assign out_tuple_valid = out_tuple_r;
  assign out_finished    = out_fin_r;

  `KSM_ASSERT(a_count_range, int'(count_r) <= NSRC, "live count beyond source count")
  `KSM_ASSERT(a_search_bounds, lo_r <= hi_r, "search window inverted")
  `KSM_ASSERT(a_ram_port, !(ram_we && ram_re), "head store read and written together")
  `KSM_ASSERT(a_emit_free, !cmd.emit || !out_valid_r || out_ready, "result overwritten")
  `KSM_ASSERT_NEXT(a_emit_valid, cmd.emit, out_valid_r, "emitted result not presented")

endmodule

`default_nettype wire

>>> hw/rtl/kway_sorted_stream_merge.sv
// Top level of the k-way sorted stream merge
//
//  Channel  Dir  Handshake             Payload
//  cfg      in   cfg_tvalid/tready     active source count
//  in       in   in_tvalid/tready      head tuple or end mark of one source
//  out      out  out_tvalid/tready     smallest head and its source, or finish
//
//  A fill item or an ignored item is loaded and decoded. A refill searches the
//  order of the live heads, inserts the new head, then reads and emits the
//  smallest head; an end mark removes its source and goes on to that read.
//  The item that completes the fill builds the order: the scan reads the key
//  of each live source and places it by binary search, then the result is
//  emitted. All searches go through the single read port of the head store.
//  Reset is synchronous, active low; heads are undefined until written.
//  A result waits in the output register while the next request is taken.
`default_nettype none

module kway_sorted_stream_merge #(
  parameter int MAX_SOURCES = 8,
  parameter int KEY_BITS    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [7:0]  cfg_tdata,   // [3:0] active_sources
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,    // [31:0] term, [63:32] doc
  input  logic [3:0]  in_tuser,    // [2:0] source, [3] exhausted
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // [31:0] out_term, [63:32] out_doc
  output logic [3:0]  out_tuser,   // [2:0] out_source, [3] tuple_valid
  output logic        out_tlast    // finished
);

  ksm_pkg::cmd_t                cmd;
  ksm_pkg::sts_t                sts;
  logic [ksm_pkg::TERM_W-1:0]   o_term;
  logic [ksm_pkg::DOC_W-1:0]    o_doc;
  logic [ksm_pkg::SRC_W-1:0]    o_source;
  logic                         o_tuple;

  assign cfg_tready = 1'b1;

  ksm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ksm_dp #(
    .MAX_SOURCES (MAX_SOURCES),
    .KEY_BITS    (KEY_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_tvalid),
    .cfg_data        (cfg_tdata[ksm_pkg::CFG_W-1:0]),
    .in_source       (in_tuser[2:0]),
    .in_term         (in_tdata[31:0]),
    .in_doc          (in_tdata[63:32]),
    .in_exhausted    (in_tuser[3]),
    .out_ready       (out_tready),
    .out_valid       (out_tvalid),
    .out_term        (o_term),
    .out_doc         (o_doc),
    .out_source      (o_source),
    .out_tuple_valid (o_tuple),
    .out_finished    (out_tlast),
    .cmd             (cmd),
    .sts             (sts)
  );

  assign out_tdata = {o_doc, o_term};
  assign out_tuser = {o_tuple, o_source};

endmodule

`default_nettype wire
